// ===== design/sfr_pkg.sv =====
package sfr_pkg;

	// Depth of the frame buffer, in bytes; only the body bytes are stored in it.
	localparam int FRAME_BYTES = 32;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);

	// Largest length byte accepted: the buffer size minus three.
	localparam logic [7:0] MAX_LEN = 8'(FRAME_BYTES - 3);

	// Configuration register indexes.
	localparam logic [1:0] REG_HEADER  = 2'd0;
	localparam logic [1:0] REG_MIN_LEN = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	// Configuration reset values.
	localparam logic [7:0] HEADER_RST  = 8'd170;
	localparam logic [7:0] MIN_LEN_RST = 8'd1;
	localparam logic [7:0] TIMEOUT_RST = 8'd220;

	// Input kinds on the tuser bit.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Result of the shared adder and comparator.
	typedef struct packed {
		logic [7:0] sum;
		logic       eq;
	} alu_res_t;

endpackage

// ===== design/sfr_alu.sv =====
// Shared 8-bit adder with an equality compare of the sum against a third operand.
module sfr_alu (
	input  logic [7:0]        a,
	input  logic [7:0]        b,
	input  logic [7:0]        c,
	output sfr_pkg::alu_res_t res
);

	logic [7:0] sum;

	assign sum     = a + b;
	assign res.sum = sum;
	assign res.eq  = (sum == c);

endmodule

// ===== design/sfr_store.sv =====
// Frame body buffer: one write port, one registered read port.
module sfr_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [sfr_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic [sfr_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                 rdata
);

	logic [7:0] mem [sfr_pkg::FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/serial_frame_receiver_core.sv =====
// Serial frame receiver. Each input word is either a received byte (tuser = 0,
// byte in tdata) or one timer tick (tuser = 1). A frame is a header byte, a
// length byte L, L body bytes (command first, then data) and a checksum byte
// equal to the 8-bit sum of the body, or zero when L is below min_length.
// Length bytes of zero or above the buffer size minus three drop the frame.
// A frame with a good checksum is sent out as a run of L words, the command
// word flagged on tuser and the final word flagged on tlast; a bad frame
// produces nothing. Any byte clears the idle counter, and timeout_ticks ticks
// in a row with no byte send the receiver back to hunting for a header.
// Rate: every byte and tick is taken in a single cycle while a frame is being
// collected. After the checksum byte of a good frame the receiver stops
// taking words and reads the buffer out word by word: a buffer read (ST_RD),
// then a load of the output register (ST_LOAD), which waits while the sink
// holds the register full. The input stays held off until the last word is
// loaded. The single buffer read port and the one shared adder set this pace.
module serial_frame_receiver_core (
	input  logic       clk,
	input  logic       arst_n,
	// Input stream.
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       s_tuser,   // [0] req_type
	// Output stream.
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] is_command
	output logic       m_tlast,
	// Configuration write port.
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	// Sequencer states.
	localparam logic [2:0] ST_WAIT = 3'd0;  // hunting for a header byte
	localparam logic [2:0] ST_LEN  = 3'd1;  // expecting the length byte
	localparam logic [2:0] ST_BODY = 3'd2;  // collecting body and checksum
	localparam logic [2:0] ST_RD   = 3'd3;  // buffer read issued
	localparam logic [2:0] ST_LOAD = 3'd4;  // loading the output register

	logic [2:0] state_q;
	logic [7:0] header_q;
	logic [7:0] min_len_q;
	logic [7:0] timeout_q;
	logic [7:0] idle_q;
	logic [7:0] len_q;
	logic [7:0] cnt_q;
	logic [7:0] sum_q;
	logic [7:0] rd_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_cmd_q;
	logic       out_last_q;

	logic       in_accept;
	logic       is_byte;
	logic       is_tick;
	logic       body_done;
	logic [7:0] expected;
	logic [7:0] idle_inc;
	logic       load_ok;

	logic [7:0]        alu_a;
	logic [7:0]        alu_b;
	logic [7:0]        alu_c;
	sfr_pkg::alu_res_t alu_res;

	logic                       mem_we;
	logic [sfr_pkg::ADDR_W-1:0] mem_waddr;
	logic [sfr_pkg::ADDR_W-1:0] mem_raddr;
	logic [7:0]                 mem_rdata;

	assign s_tready  = (state_q == ST_WAIT) || (state_q == ST_LEN) || (state_q == ST_BODY);
	assign in_accept = s_tvalid && s_tready;
	assign is_byte   = in_accept && (s_tuser == sfr_pkg::KIND_BYTE);
	assign is_tick   = in_accept && (s_tuser == sfr_pkg::KIND_TICK);

	// All body bytes are in once the count reaches the length; the next byte is the checksum.
	assign body_done = (cnt_q == len_q);
	assign expected  = (len_q < min_len_q) ? 8'd0 : sum_q;
	assign idle_inc  = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;

	// The shared unit accumulates the body sum, checks the checksum, and during
	// readout steps the read index and spots the final word.
	always_comb begin
		alu_a = sum_q;
		alu_b = s_tdata;
		alu_c = s_tdata;
		case (state_q)
			ST_BODY: begin
				if (body_done) begin
					alu_a = expected;
					alu_b = 8'd0;
				end
			end
			ST_LOAD: begin
				alu_a = rd_q;
				alu_b = 8'd1;
				alu_c = len_q;
			end
			default: begin
				alu_a = sum_q;
			end
		endcase
	end

	sfr_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.res (alu_res)
	);

	assign mem_we    = is_byte && (state_q == ST_BODY) && !body_done;
	assign mem_waddr = cnt_q[sfr_pkg::ADDR_W-1:0];
	assign mem_raddr = rd_q[sfr_pkg::ADDR_W-1:0];

	sfr_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (s_tdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The output register can take a new word when it is empty or being drained.
	assign load_ok = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= sfr_pkg::HEADER_RST;
			min_len_q <= sfr_pkg::MIN_LEN_RST;
			timeout_q <= sfr_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sfr_pkg::REG_HEADER:  header_q  <= cfg_data;
				sfr_pkg::REG_MIN_LEN: min_len_q <= cfg_data;
				sfr_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WAIT;
			idle_q      <= 8'd0;
			len_q       <= 8'd0;
			cnt_q       <= 8'd0;
			sum_q       <= 8'd0;
			rd_q        <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			// A load refills the output register; otherwise a taken word empties it.
			if ((state_q == ST_LOAD) && load_ok) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (is_tick) begin
				// A timeout abandons any partial frame.
				if (idle_inc >= timeout_q) begin
					idle_q  <= 8'd0;
					state_q <= ST_WAIT;
				end else begin
					idle_q <= idle_inc;
				end
			end else if (is_byte) begin
				idle_q <= 8'd0;
				case (state_q)
					ST_LEN: begin
						if ((s_tdata == 8'd0) || (s_tdata > sfr_pkg::MAX_LEN)) begin
							state_q <= ST_WAIT;
						end else begin
							len_q   <= s_tdata;
							cnt_q   <= 8'd0;
							sum_q   <= 8'd0;
							state_q <= ST_BODY;
						end
					end
					ST_BODY: begin
						if (body_done) begin
							// Checksum byte: a match starts readout, a mismatch drops the frame.
							rd_q    <= 8'd0;
							state_q <= alu_res.eq ? ST_RD : ST_WAIT;
						end else begin
							sum_q <= alu_res.sum;
							cnt_q <= cnt_q + 8'd1;
						end
					end
					default: begin
						state_q <= (s_tdata == header_q) ? ST_LEN : ST_WAIT;
					end
				endcase
			end else begin
				case (state_q)
					ST_RD: begin
						state_q <= ST_LOAD;
					end
					ST_LOAD: begin
						if (load_ok) begin
							if (alu_res.eq) begin
								state_q <= ST_WAIT;
							end else begin
								rd_q    <= alu_res.sum;
								state_q <= ST_RD;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Output payload; only loaded together with the valid flag.
	always_ff @(posedge clk) begin
		if ((state_q == ST_LOAD) && load_ok) begin
			out_byte_q <= mem_rdata;
			out_cmd_q  <= (rd_q == 8'd0);
			out_last_q <= alu_res.eq;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_cmd_q;
	assign m_tlast  = out_last_q;

endmodule
